// ===== design/dcnf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcnf_pkg
// Shared types, character codes and the byte classifier of the DIMACS CNF
// literal parser.
// ----------------------------------------------------------------------------
package dcnf_pkg;

  localparam int LitBits = 21;

  // Character codes
  localparam logic [7:0] CharEnd   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharNl    = 8'h0a;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharC     = 8'h63;
  localparam logic [7:0] CharP     = 8'h70;

  // Result kinds
  localparam logic [1:0] KindLiteral   = 2'd0;
  localparam logic [1:0] KindClauseEnd = 2'd1;
  localparam logic [1:0] KindTextEnd   = 2'd2;
  localparam logic [1:0] KindError     = 2'd3;

  // Error codes
  localparam logic ErrUnexpected = 1'b0;
  localparam logic ErrOverflow   = 1'b1;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_DIGIT,
    CLS_MINUS,
    CLS_PLUS,
    CLS_SKIP,
    CLS_END,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    logic [7:0] data;
    cls_e       cls;
    logic       is_nl;
  } tok_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [LitBits-1:0] literal;
    logic               error_code;
    logic [7:0]         bad_byte;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    a;
    result_t    b;
  } push_t;

  function automatic cls_e classify(logic [7:0] b);
    cls_e c;
    if ((b >= CharTab && b <= CharCr) || b == CharSpace) begin
      c = CLS_SPACE;
    end else if (b >= CharZero && b <= CharNine) begin
      c = CLS_DIGIT;
    end else if (b == CharMinus) begin
      c = CLS_MINUS;
    end else if (b == CharPlus) begin
      c = CLS_PLUS;
    end else if (b == CharC || b == CharP) begin
      c = CLS_SKIP;
    end else if (b == CharEnd) begin
      c = CLS_END;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/dcnf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcnf_front
// Accepts text bytes, classifies them and holds them in a two-entry token
// queue for the parser back end.
// ----------------------------------------------------------------------------
module dcnf_front import dcnf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] text_byte_i,
  output logic            tok_valid_o,
  output tok_t            tok_o,
  input  wire logic       tok_pop_i
);

  tok_t       slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  tok_t       tok_new;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = slot_q[rptr_q];

  always_comb begin
    tok_new.data  = text_byte_i;
    tok_new.cls   = classify(text_byte_i);
    tok_new.is_nl = (text_byte_i == CharNl);
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = tok_pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(tok_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= tok_new;
    end
  end

endmodule
`default_nettype wire

// ===== design/dcnf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcnf_back
// Parser state machine: consumes one classified token per cycle while the
// result queue has space and produces up to two results into the result queue.
// ----------------------------------------------------------------------------
module dcnf_back import dcnf_pkg::*; #(
  parameter int VarBits = 20
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic tok_valid_i,
  input  wire tok_t tok_i,
  output logic      tok_pop_o,
  input  wire logic space_ok_i,
  output push_t     push_o
);

  localparam int AccW = VarBits + 1;
  localparam int SumW = VarBits + 5;
  localparam int LitW = (VarBits + 2 > LitBits) ? VarBits + 2 : LitBits;
  localparam logic [SumW-1:0] Limit = SumW'(1) << VarBits;

  localparam logic [2:0] ModeClause = 3'd0;
  localparam logic [2:0] ModeSkip   = 3'd1;
  localparam logic [2:0] ModeIn     = 3'd2;
  localparam logic [2:0] ModeSign   = 3'd3;
  localparam logic [2:0] ModeDigits = 3'd4;

  logic [2:0]      mode_q, mode_d;
  logic            neg_q, neg_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            halt_q, halt_d;

  logic [2:0]      eff_mode;
  logic [AccW-1:0] acc_base;
  logic [3:0]      digit;
  logic [SumW-1:0] sum;
  logic            ovf;
  logic [LitW-1:0] lit_wide;
  logic            have_a, have_b;
  logic            start_num, do_add;
  result_t         res_a, res_b;

  assign tok_pop_o = tok_valid_i && space_ok_i;
  assign acc_base  = (mode_q == ModeDigits) ? acc_q : '0;
  assign digit     = tok_i.data[3:0];
  assign sum       = (SumW'(acc_base) << 3) + (SumW'(acc_base) << 1) + SumW'(digit);
  assign ovf       = (sum > Limit);
  assign lit_wide  = LitW'({acc_q - AccW'(1), neg_q});

  always_comb begin
    mode_d    = mode_q;
    neg_d     = neg_q;
    acc_d     = acc_q;
    halt_d    = halt_q;
    eff_mode  = mode_q;
    have_a    = 1'b0;
    have_b    = 1'b0;
    start_num = 1'b0;
    do_add    = 1'b0;
    res_a     = '0;
    res_b     = '0;

    if (tok_pop_o && !halt_q) begin
      if (mode_q == ModeDigits && tok_i.cls == CLS_DIGIT) begin
        do_add = 1'b1;
      end else begin
        // close the pending number first
        if (mode_q == ModeDigits) begin
          have_a = 1'b1;
          neg_d  = 1'b0;
          acc_d  = '0;
          if (acc_q == '0) begin
            res_a.kind = KindClauseEnd;
            eff_mode   = ModeClause;
          end else begin
            res_a.kind    = KindLiteral;
            res_a.literal = lit_wide[LitBits-1:0];
            eff_mode      = ModeIn;
          end
          mode_d = eff_mode;
        end

        case (eff_mode)
          ModeSkip: begin
            if (tok_i.cls == CLS_END) begin
              have_b     = 1'b1;
              res_b.kind = KindTextEnd;
              halt_d     = 1'b1;
            end else if (tok_i.is_nl) begin
              mode_d = ModeClause;
            end
          end
          ModeIn: begin
            if (tok_i.cls != CLS_SPACE) begin
              start_num = 1'b1;
            end
          end
          ModeSign: begin
            if (tok_i.cls == CLS_DIGIT) begin
              do_add = 1'b1;
            end else begin
              have_b           = 1'b1;
              res_b.kind       = KindError;
              res_b.error_code = ErrUnexpected;
              res_b.bad_byte   = tok_i.data;
              halt_d           = 1'b1;
            end
          end
          default: begin
            if (tok_i.cls == CLS_SPACE) begin
              mode_d = eff_mode;
            end else if (tok_i.cls == CLS_END) begin
              have_b     = 1'b1;
              res_b.kind = KindTextEnd;
              halt_d     = 1'b1;
            end else if (tok_i.cls == CLS_SKIP) begin
              mode_d = ModeSkip;
            end else begin
              start_num = 1'b1;
            end
          end
        endcase

        if (start_num) begin
          neg_d = 1'b0;
          acc_d = '0;
          case (tok_i.cls)
            CLS_MINUS: begin
              neg_d  = 1'b1;
              mode_d = ModeSign;
            end
            CLS_PLUS: begin
              mode_d = ModeSign;
            end
            CLS_DIGIT: begin
              do_add = 1'b1;
            end
            default: begin
              have_b           = 1'b1;
              res_b.kind       = KindError;
              res_b.error_code = ErrUnexpected;
              res_b.bad_byte   = tok_i.data;
              halt_d           = 1'b1;
            end
          endcase
        end
      end

      if (do_add) begin
        if (ovf) begin
          have_b           = 1'b1;
          res_b.kind       = KindError;
          res_b.error_code = ErrOverflow;
          res_b.bad_byte   = tok_i.data;
          halt_d           = 1'b1;
        end else begin
          acc_d  = sum[AccW-1:0];
          mode_d = ModeDigits;
        end
      end
    end

    push_o.cnt    = {have_a && have_b, have_a ^ have_b};
    push_o.a      = have_a ? res_a : res_b;
    push_o.a.last = !(have_a && have_b);
    push_o.b      = res_b;
    push_o.b.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeClause;
      neg_q  <= 1'b0;
      acc_q  <= '0;
      halt_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      neg_q  <= neg_d;
      acc_q  <= acc_d;
      halt_q <= halt_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/dcnf_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcnf_outq
// Four-entry result queue: takes up to two results per cycle from the
// back end and presents one transaction per cycle on the output while not stalled.
// ----------------------------------------------------------------------------
module dcnf_outq import dcnf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       space_ok_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output result_t    head_o
);

  result_t    entry_q [4];
  logic [1:0] wptr_q, wptr_d;
  logic [1:0] rptr_q, rptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign space_ok_o  = (cnt_q <= 3'd2);
  assign out_valid_o = (cnt_q != 3'd0);
  assign head_o      = entry_q[rptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wptr_d = wptr_q + push_i.cnt;
    rptr_d = rptr_q + 2'(pop);
    cnt_d  = cnt_q + 3'(push_i.cnt) - 3'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 2'd0;
      rptr_q <= 2'd0;
      cnt_q  <= 3'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entry_q[wptr_q] <= push_i.a;
    end
    if (push_i.cnt == 2'd2) begin
      entry_q[wptr_q + 2'd1] <= push_i.b;
    end
  end

endmodule
`default_nettype wire

// ===== design/dimacs_cnf_literal_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dimacs_cnf_literal_parser_core
// Streaming DIMACS CNF tokenizer producing encoded literals, clause ends,
// end of text and errors.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while it does not stall. A front
// end classifies each byte into a two-entry token queue; the parser state
// machine consumes one token per cycle while the result queue has space and
// writes up to two results into a four-entry result queue that drives the
// output channel. A byte that ends a number and is itself reported (end of
// text, error) yields two results, each a transaction of its own on the
// output; otherwise the sustained rate is one byte per cycle when neither
// channel stalls. The byte is registered in the token queue and its result
// in the result queue before the result is presented on the output. After an
// error or end of text all further bytes are accepted and dropped until reset.
module dimacs_cnf_literal_parser_core import dcnf_pkg::*; #(
  parameter int VarBits = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         text_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              kind_o,
  output logic [LitBits-1:0]      literal_o,
  output logic                    error_code_o,
  output logic [7:0]              bad_byte_o,
  output logic                    last_of_run_o
);

  logic    tok_valid;
  tok_t    tok;
  logic    tok_pop;
  logic    space_ok;
  push_t   push;
  result_t head;

  dcnf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  dcnf_back #(
    .VarBits (VarBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .space_ok_i  (space_ok),
    .push_o      (push)
  );

  dcnf_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o        = head.kind;
  assign literal_o     = head.literal;
  assign error_code_o  = head.error_code;
  assign bad_byte_o    = head.bad_byte;
  assign last_of_run_o = head.last;

`ifndef SYNTHESIS
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindError || kind_o == KindTextEnd) |-> last_of_run_o)
    else $error("error or end of text not last of run");

  a_nonlit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KindLiteral |-> literal_o == '0)
    else $error("literal field set on non-literal transaction");

  a_noerr_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KindError |-> !error_code_o && bad_byte_o == 8'd0)
    else $error("error fields set on non-error transaction");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DIMACS CNF literal parser core.
// Streams CNF text one byte per transaction through the input channel and
// predicts every literal, clause end, end of text and error in a
// cycle-free model of the tokenizer. The output channel is checked in order
// against the model. The stimulus starts with a short hand-written text.
// Random well-formed clauses and comment lines follow, with random gaps and
// stalls on both channels after the first batch. The run closes with one
// randomly chosen text end or error case, then noise the halted block must drop.
// ----------------------------------------------------------------------------
module tb;
  import dcnf_pkg::*;

  localparam int VarBits = 20;
  localparam int unsigned MaxVar = 2 ** VarBits;
  localparam int IdleLimit = 4000;
  localparam int DrainCycles = 20;
  localparam logic [7:0] CharVt = 8'h0b;
  localparam logic [7:0] CharFf = 8'h0c;

  typedef enum logic [2:0] {
    SCAN_CLAUSE,
    SCAN_SKIP,
    SCAN_INSIDE,
    SCAN_SIGN,
    SCAN_DIGITS
  } scan_e;

  typedef enum int {
    END_AT_CLAUSE,
    END_IN_COMMENT,
    END_AFTER_ZERO,
    END_IN_CLAUSE,
    END_AFTER_LITERAL,
    END_BAD_SIGN,
    END_STRAY_IN_CLAUSE,
    END_STRAY_AT_CLAUSE,
    END_OVERFLOW,
    END_NUMBER_STRAY
  } ending_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         text_byte_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         kind_o;
  logic [LitBits-1:0] literal_o;
  logic               error_code_o;
  logic [7:0]         bad_byte_o;
  logic               last_of_run_o;

  scan_e           scan_mode = SCAN_CLAUSE;
  logic            scan_negative = 1'b0;
  longint unsigned scan_value = 0;
  bit              scan_halted = 1'b0;
  result_t         step_tokens[$];
  result_t         pending_tokens[$];

  bit    idle_on = 1'b0;
  int    stall_left = 0;
  int    idle_cycles = 0;
  int    bytes_sent = 0;
  int    tokens_checked = 0;
  int    literals_seen = 0;
  int    clause_ends_seen = 0;
  int    mismatches = 0;
  string ending_name = "none";

  dimacs_cnf_literal_parser_core #(
    .VarBits(VarBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .literal_o    (literal_o),
    .error_code_o (error_code_o),
    .bad_byte_o   (bad_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit is_blank(logic [7:0] b);
    return (b >= CharTab && b <= CharCr) || b == CharSpace;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= CharZero && b <= CharNine;
  endfunction

  function automatic void emit(logic [1:0] kind, logic [LitBits-1:0] lit, logic code,
                               logic [7:0] bad);
    result_t r;
    r.kind = kind;
    r.literal = lit;
    r.error_code = code;
    r.bad_byte = bad;
    r.last = 1'b0;
    step_tokens.push_back(r);
  endfunction

  function automatic void halt_on(logic code, logic [7:0] b);
    scan_halted = 1'b1;
    emit(KindError, '0, code, b);
  endfunction

  function automatic void take_digit(logic [7:0] b);
    longint unsigned d;
    d = b - CharZero;
    if (scan_value > (MaxVar - d) / 10) begin
      halt_on(ErrOverflow, b);
    end else begin
      scan_value = scan_value * 10 + d;
      scan_mode = SCAN_DIGITS;
    end
  endfunction

  function automatic void open_number(logic [7:0] b);
    scan_negative = 1'b0;
    scan_value = 0;
    if (b == CharMinus) begin
      scan_negative = 1'b1;
      scan_mode = SCAN_SIGN;
    end else if (b == CharPlus) begin
      scan_mode = SCAN_SIGN;
    end else if (is_digit(b)) begin
      take_digit(b);
    end else begin
      halt_on(ErrUnexpected, b);
    end
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    longint unsigned lit;
    bit done;
    step_tokens.delete();
    done = scan_halted;
    if (!done && scan_mode == SCAN_DIGITS) begin
      if (is_digit(b)) begin
        take_digit(b);
        done = 1'b1;
      end else begin
        if (scan_value == 0) begin
          emit(KindClauseEnd, '0, 1'b0, '0);
          scan_mode = SCAN_CLAUSE;
          clause_ends_seen++;
        end else begin
          lit = 2 * (scan_value - 1) + scan_negative;
          emit(KindLiteral, lit[LitBits-1:0], 1'b0, '0);
          scan_mode = SCAN_INSIDE;
          literals_seen++;
        end
        scan_negative = 1'b0;
        scan_value = 0;
      end
    end
    if (!done) begin
      case (scan_mode)
        SCAN_SKIP: begin
          if (b == CharEnd) begin
            scan_halted = 1'b1;
            emit(KindTextEnd, '0, 1'b0, '0);
          end else if (b == CharNl) begin
            scan_mode = SCAN_CLAUSE;
          end
        end
        SCAN_INSIDE: begin
          if (!is_blank(b)) open_number(b);
        end
        SCAN_SIGN: begin
          if (is_digit(b)) take_digit(b);
          else halt_on(ErrUnexpected, b);
        end
        default: begin
          if (is_blank(b)) begin
          end else if (b == CharEnd) begin
            scan_halted = 1'b1;
            emit(KindTextEnd, '0, 1'b0, '0);
          end else if (b == CharC || b == CharP) begin
            scan_mode = SCAN_SKIP;
          end else begin
            open_number(b);
          end
        end
      endcase
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic int pick_idle();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_idle();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    text_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scan_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(9))
      0, 1, 2, 3: return CharSpace;
      4, 5:       return CharNl;
      6:          return CharTab;
      7:          return CharVt;
      8:          return CharFf;
      default:    return CharCr;
    endcase
  endfunction

  task automatic send_blanks(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) send_byte(pick_blank());
  endtask

  function automatic string pick_sign();
    int r;
    r = $urandom_range(99);
    if (r < 40) return "-";
    if (r < 50) return "+";
    return "";
  endfunction

  function automatic int unsigned pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(30, 1);
    if (r < 85) return $urandom_range(MaxVar, 1);
    if (r < 95) return MaxVar;
    return 1;
  endfunction

  task automatic send_clause();
    int    n_lits;
    string sgn;
    string pad;
    n_lits = $urandom_range(6);
    for (int i = 0; i <= n_lits; i++) begin
      sgn = pick_sign();
      pad = ($urandom_range(9) == 0) ? "00" : "";
      if (sgn.len() == 0 || $urandom_range(4) != 0) send_blanks(1, 3);
      if (i == n_lits) send_text({sgn, pad, "0"});
      else send_text($sformatf("%s%s%0d", sgn, pad, pick_value()));
    end
  endtask

  task automatic send_comment();
    int         len;
    logic [7:0] b;
    send_blanks(0, 2);
    send_byte($urandom_range(1) ? CharC : CharP);
    len = $urandom_range(12);
    repeat (len) begin
      b = $urandom_range(255, 1);
      if (b == CharNl) b = CharSpace;
      send_byte(b);
    end
    send_byte(CharNl);
  endtask

  task automatic wait_for_tokens();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    send_text("c");
    send_byte(8'hff);
    send_byte(CharNl);
    send_text("-1048576 1048576+1");
    send_byte(CharTab);
    send_text("007");
    send_byte(CharCr);
    send_text("-0");
    send_byte(CharVt);
  endtask

  task automatic test_random_cnf(input int count, input bit with_idle);
    int stop_at;
    idle_on = with_idle;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(6) == 0) send_comment();
      else send_clause();
    end
  endtask

  task automatic test_text_end();
    ending_e    ending;
    logic [7:0] b;
    idle_on = 1'b1;
    ending = ending_e'($urandom_range(END_NUMBER_STRAY));
    ending_name = ending.name();
    send_byte(CharNl);
    case (ending)
      END_AT_CLAUSE: begin
        send_byte(CharEnd);
      end
      END_IN_COMMENT: begin
        send_text("c eof");
        send_byte(CharEnd);
      end
      END_AFTER_ZERO: begin
        send_text("3 0");
        send_byte(CharEnd);
      end
      END_IN_CLAUSE: begin
        send_text("3 ");
        send_byte(CharEnd);
      end
      END_AFTER_LITERAL: begin
        send_text("-3");
        send_byte(CharEnd);
      end
      END_BAD_SIGN: begin
        send_byte($urandom_range(1) ? CharMinus : CharPlus);
        do b = $urandom_range(255); while (is_digit(b));
        send_byte(b);
      end
      END_STRAY_IN_CLAUSE: begin
        send_text("3 ");
        do b = $urandom_range(255);
        while (is_blank(b) || is_digit(b) || b == CharMinus || b == CharPlus);
        send_byte(b);
      end
      END_STRAY_AT_CLAUSE: begin
        do b = $urandom_range(255);
        while (is_blank(b) || is_digit(b) || b == CharMinus || b == CharPlus ||
               b == CharC || b == CharP || b == CharEnd);
        send_byte(b);
      end
      END_OVERFLOW: begin
        send_text($sformatf("%s%0d ", pick_sign(), $urandom_range(99999999, MaxVar + 1)));
      end
      default: begin
        send_text("12");
        do b = $urandom_range(255);
        while (is_digit(b) || is_blank(b) || b == CharMinus || b == CharPlus);
        send_byte(b);
      end
    endcase
    wait_for_tokens();
    repeat (30) send_byte($urandom_range(255));
    wait_for_tokens();
  endtask

  function automatic void note_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected kind %0d literal %0d code %0d byte %02h last %0b,",
               $realtime, what, want.kind, want.literal, want.error_code, want.bad_byte,
               want.last);
      $display("    got kind %0d literal %0d code %0d byte %02h last %0b",
               got.kind, got.literal, got.error_code, got.bad_byte, got.last);
    end
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(99) < 25) begin
      stall_left = ($urandom_range(19) == 0) ? $urandom_range(40, 8) : $urandom_range(2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {kind_o, literal_o, error_code_o, bad_byte_o, last_of_run_o};
      if (pending_tokens.size() == 0) begin
        note_mismatch("unexpected transaction", '0, got);
      end else begin
        want = pending_tokens.pop_front();
        if (got.kind !== want.kind || got.literal !== want.literal ||
            got.error_code !== want.error_code || got.bad_byte !== want.bad_byte ||
            got.last !== want.last) begin
          note_mismatch("wrong transaction", want, got);
        end
      end
      tokens_checked++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d cycles without a transaction", IdleLimit);
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    wait_for_tokens();
    test_random_cnf(300, 1'b0);
    test_random_cnf(700, 1'b1);
    wait_for_tokens();
    test_random_cnf(600, 1'b1);
    test_text_end();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_tokens.size() != 0) begin
      $display("%0d expected transactions never arrived", pending_tokens.size());
      mismatches += pending_tokens.size();
    end
    $display("covered %0d text bytes, %0d output transactions, %0d literals, %0d clause ends",
             bytes_sent, tokens_checked, literals_seen, clause_ends_seen);
    $display("text closed by %s, then noise dropped by the halted parser", ending_name);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
